>>> sv/hrlp_pkg.sv
// Package for the HTTP request line parser.
// Holds the parse phase, status and method codes, the per-line state record
// and the result record. It depends on nothing else.
`default_nettype none

package hrlp_pkg;

  localparam int unsigned OFF_W = 13;

  typedef logic [OFF_W-1:0] offset_t;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_METHOD  = 4'd1,
    PH_SP_URI  = 4'd2,
    PH_URI     = 4'd3,
    PH_SP_HTTP = 4'd4,
    PH_H       = 4'd5,
    PH_HT      = 4'd6,
    PH_HTT     = 4'd7,
    PH_HTTP    = 4'd8,
    PH_MAJ1    = 4'd9,
    PH_MAJ     = 4'd10,
    PH_MIN1    = 4'd11,
    PH_MIN     = 4'd12,
    PH_SP_END  = 4'd13,
    PH_ALMOST  = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_BAD_METHOD  = 2'd1,
    ST_BAD_REQUEST = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    M_GET     = 2'd0,
    M_POST    = 2'd1,
    M_HEAD    = 2'd2,
    M_UNKNOWN = 2'd3
  } method_t;

  localparam logic [2:0] METHOD_LEN_MAX = 3'd5;

  typedef struct packed {
    phase_t          phase;
    offset_t         start_offset;
    logic [3:0][7:0] method_chars;
    logic [2:0]      method_len;
    offset_t         uri_start_offset;
    offset_t         uri_end_offset;
    method_t         method_code;
    logic [7:0]      major_acc;
    logic [7:0]      minor_acc;
    logic            saw_cr;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    phase:            PH_START,
    start_offset:     '0,
    method_chars:     '0,
    method_len:       '0,
    uri_start_offset: '0,
    uri_end_offset:   '0,
    method_code:      M_UNKNOWN,
    major_acc:        '0,
    minor_acc:        '0,
    saw_cr:           1'b0
  };

  typedef struct packed {
    status_t    status;
    method_t    method;
    offset_t    line_start;
    offset_t    uri_begin;
    offset_t    uri_finish;
    offset_t    line_finish;
    logic [7:0] version_major;
    logic [7:0] version_minor;
  } result_t;

endpackage

`default_nettype wire

>>> sv/http_request_line_parser_unit.sv
// A transferred byte is held in byte_reg; its result is then registered in res.
// Throughput: one byte per cycle unless a held result stalls the byte stage.
// Result stall backs up into the byte register and then into req_stall.
// Reset clears the parse state, the byte offset counter and both valid flags.
// Top level of the HTTP request line parser. Uses hrlp_pkg and hrlp_step.
`default_nettype none

module http_request_line_parser_unit
  import hrlp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [7:0]       byte_in,
  output logic             res_valid,
  input  logic             res_stall,
  output logic [1:0]       status,
  output logic [1:0]       method,
  output logic [OFF_W-1:0] line_start,
  output logic [OFF_W-1:0] uri_begin,
  output logic [OFF_W-1:0] uri_finish,
  output logic [OFF_W-1:0] line_finish,
  output logic [7:0]       version_major,
  output logic [7:0]       version_minor
);

  logic        byte_valid;
  logic [7:0]  byte_reg;
  offset_t     byte_position;
  line_state_t line;
  line_state_t line_next;
  logic        emit;
  result_t     step_result;
  result_t     res;
  logic        advance;
  logic        req_take;

  assign advance   = byte_valid && (!res_valid || !res_stall);
  assign req_stall = byte_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  hrlp_step u_step (
    .cur     (line),
    .byte_in (byte_reg),
    .pos     (byte_position),
    .nxt     (line_next),
    .emit    (emit),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid    <= 1'b0;
      byte_position <= '0;
      line          <= LINE_RESET;
      res_valid     <= 1'b0;
    end else begin
      byte_valid <= req_take || (byte_valid && !advance);
      res_valid  <= (advance && emit) || (res_valid && res_stall);
      if (advance) begin
        byte_position <= byte_position + 1'b1;
        line          <= line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      byte_reg <= byte_in;
    end
    if (advance && emit) begin
      res <= step_result;
    end
  end

  assign status        = res.status;
  assign method        = res.method;
  assign line_start    = res.line_start;
  assign uri_begin     = res.uri_begin;
  assign uri_finish    = res.uri_finish;
  assign line_finish   = res.line_finish;
  assign version_major = res.version_major;
  assign version_minor = res.version_minor;

`ifndef ASSERT_OFF
  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (line.phase == PH_START))
    else $error("parser did not return to the start phase after a result");

  a_method_len_bound: assert property (@(posedge clk) disable iff (rst)
    line.method_len <= METHOD_LEN_MAX)
    else $error("method length counter ran past its limit");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> byte_valid)
    else $error("input stalled with an empty byte register");

  a_result_status_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.status == ST_DONE || res.status == ST_BAD_METHOD ||
                   res.status == ST_BAD_REQUEST))
    else $error("result carries an undefined status");

  a_offset_advances: assert property (@(posedge clk) disable iff (rst)
    advance |=> (byte_position == $past(byte_position) + 1'b1))
    else $error("byte offset did not advance with a processed byte");
`endif

endmodule

`default_nettype wire

>>> sv/hrlp_step.sv
// Next-state logic of the request line parser for one byte.
// Combinational: takes the per-line state, the byte and its offset, and gives
// the next state and a result when the line ends or breaks. Uses hrlp_pkg.
`default_nettype none

module hrlp_step
  import hrlp_pkg::*;
(
  input  line_state_t cur,
  input  logic [7:0]  byte_in,
  input  offset_t     pos,
  output line_state_t nxt,
  output logic        emit,
  output result_t     result
);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  function automatic logic is_method_char(input logic [7:0] c);
    return ((c >= CH_A) && (c <= CH_Z)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [7:0] sat_acc(input logic [7:0] acc, input logic [7:0] c);
    logic [11:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {8'b0, c[3:0]};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic method_t match_method(input logic [3:0][7:0] m,
                                           input logic [2:0] len);
    method_t code;
    code = M_UNKNOWN;
    if ((len == 3'd3) && (m[0] == CH_G) && (m[1] == CH_E) && (m[2] == CH_T)) begin
      code = M_GET;
    end else if ((len == 3'd4) && (m[0] == CH_P) && (m[1] == CH_O) &&
                 (m[2] == CH_S) && (m[3] == CH_T)) begin
      code = M_POST;
    end else if ((len == 3'd4) && (m[0] == CH_H) && (m[1] == CH_E) &&
                 (m[2] == CH_A) && (m[3] == CH_D)) begin
      code = M_HEAD;
    end
    return code;
  endfunction

  line_state_t upd;
  status_t     status;
  offset_t     prev;

  assign prev = pos - 1'b1;

  always_comb begin
    upd    = cur;
    emit   = 1'b0;
    status = ST_DONE;
    unique case (cur.phase)
      PH_START: begin
        upd.start_offset = pos;
        if ((byte_in == CH_CR) || (byte_in == CH_LF)) begin
          upd.phase = PH_START;
        end else if (!is_method_char(byte_in)) begin
          emit   = 1'b1;
          status = ST_BAD_METHOD;
        end else begin
          upd.method_chars[0] = byte_in;
          upd.method_len      = 3'd1;
          upd.phase           = PH_METHOD;
        end
      end
      PH_METHOD: begin
        if (byte_in == CH_SPACE) begin
          upd.method_code = match_method(cur.method_chars, cur.method_len);
          upd.phase       = PH_SP_URI;
        end else if (!is_method_char(byte_in)) begin
          emit   = 1'b1;
          status = ST_BAD_METHOD;
        end else begin
          if (cur.method_len < 3'd4) begin
            upd.method_chars[cur.method_len[1:0]] = byte_in;
          end
          if (cur.method_len < METHOD_LEN_MAX) begin
            upd.method_len = cur.method_len + 3'd1;
          end
        end
      end
      PH_SP_URI: begin
        if (byte_in == CH_SLASH) begin
          upd.uri_start_offset = pos;
          upd.phase            = PH_URI;
        end else if (byte_in != CH_SPACE) begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_URI: begin
        if (byte_in == CH_SPACE) begin
          upd.uri_end_offset = pos;
          upd.phase          = PH_SP_HTTP;
        end
      end
      PH_SP_HTTP: begin
        if (byte_in == CH_H) begin
          upd.phase = PH_H;
        end else if (byte_in != CH_SPACE) begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_H: begin
        if (byte_in == CH_T) begin
          upd.phase = PH_HT;
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_HT: begin
        if (byte_in == CH_T) begin
          upd.phase = PH_HTT;
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_HTT: begin
        if (byte_in == CH_P) begin
          upd.phase = PH_HTTP;
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_HTTP: begin
        if (byte_in == CH_SLASH) begin
          upd.phase = PH_MAJ1;
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_MAJ1: begin
        if ((byte_in < CH_1) || (byte_in > CH_9)) begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end else begin
          upd.major_acc = {4'b0, byte_in[3:0]};
          upd.phase     = PH_MAJ;
        end
      end
      PH_MAJ: begin
        if (byte_in == CH_DOT) begin
          upd.phase = PH_MIN1;
        end else if (is_digit(byte_in)) begin
          upd.major_acc = sat_acc(cur.major_acc, byte_in);
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_MIN1: begin
        if (!is_digit(byte_in)) begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end else begin
          upd.minor_acc = {4'b0, byte_in[3:0]};
          upd.phase     = PH_MIN;
        end
      end
      PH_MIN: begin
        if (byte_in == CH_CR) begin
          upd.saw_cr = 1'b1;
          upd.phase  = PH_ALMOST;
        end else if (byte_in == CH_LF) begin
          emit = 1'b1;
        end else if (byte_in == CH_SPACE) begin
          upd.phase = PH_SP_END;
        end else if (is_digit(byte_in)) begin
          upd.minor_acc = sat_acc(cur.minor_acc, byte_in);
        end else begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_SP_END: begin
        if (byte_in == CH_CR) begin
          upd.saw_cr = 1'b1;
          upd.phase  = PH_ALMOST;
        end else if (byte_in == CH_LF) begin
          emit = 1'b1;
        end else if (byte_in != CH_SPACE) begin
          emit   = 1'b1;
          status = ST_BAD_REQUEST;
        end
      end
      PH_ALMOST: begin
        emit = 1'b1;
        if (byte_in != CH_LF) begin
          status = ST_BAD_REQUEST;
        end
      end
      default: begin
        upd.phase = PH_START;
      end
    endcase
  end

  always_comb begin
    result.status        = status;
    result.method        = upd.method_code;
    result.line_start    = upd.start_offset;
    result.uri_begin     = upd.uri_start_offset;
    result.uri_finish    = upd.uri_end_offset;
    result.line_finish   = ((status == ST_DONE) && upd.saw_cr) ? prev : pos;
    result.version_major = upd.major_acc;
    result.version_minor = upd.minor_acc;
    nxt = emit ? LINE_RESET : upd;
  end

endmodule

`default_nettype wire
